// ----- rtl/core/cmc_pkg.sv -----
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared constants and types for the crossbar matching completion block.
// ----------------------------------------------------------------------------
package cmc_pkg;

  // Default number of crossbar ports
  localparam int PORTS_DEFAULT = 32;

  // Port field width on the channels
  localparam int PORT_W = 5;

  // Control from the sequencer to the free-output scanner
  typedef struct packed {
    logic              mark;       // mark mark_port as taken (if in range)
    logic [PORT_W-1:0] mark_port;  // output named by a matched input
    logic              advance;    // step the free-output pointer
    logic              clear;      // end of set: clear map and pointer
  } scan_ctrl_t;

endpackage

// ----- rtl/core/cmc_in_if.sv -----
// ----------------------------------------------------------------------------
// cmc_in_if
// Valid/ready channel carrying one loaded input port of a matching.
// ----------------------------------------------------------------------------
interface cmc_in_if;
  import cmc_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_unmatched;
  logic [PORT_W-1:0] target_port;
  logic              last_entry;

  modport source (output valid, output is_unmatched, output target_port,
                  output last_entry, input ready);
  modport sink   (input valid, input is_unmatched, input target_port,
                  input last_entry, output ready);
endinterface

// ----- rtl/core/cmc_out_if.sv -----
// ----------------------------------------------------------------------------
// cmc_out_if
// Valid/ready channel carrying one completed input-to-output pairing.
// ----------------------------------------------------------------------------
interface cmc_out_if;
  import cmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] source_port;
  logic [PORT_W-1:0] granted_port;
  logic              was_filled;
  logic              last_result;

  modport source (output valid, output source_port, output granted_port,
                  output was_filled, output last_result, input ready);
  modport sink   (input valid, input source_port, input granted_port,
                  input was_filled, input last_result, output ready);
endinterface

// ----- rtl/core/cmc_port_store.sv -----
// ----------------------------------------------------------------------------
// cmc_port_store
// Per-input store of unmatched flag and target, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module cmc_port_store #(
  parameter int PORTS = cmc_pkg::PORTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(PORTS)-1:0]    waddr,
  input  logic                        wunm,
  input  logic [cmc_pkg::PORT_W-1:0]  wtgt,
  input  logic [$clog2(PORTS)-1:0]    raddr,
  output logic                        runm,
  output logic [cmc_pkg::PORT_W-1:0]  rtgt
);
  import cmc_pkg::*;

  logic [PORT_W-1:0] tgt_mem [PORTS];
  logic              unm_mem [PORTS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      tgt_mem[waddr] <= wtgt;
      unm_mem[waddr] <= wunm;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rtgt <= tgt_mem[raddr];
    runm <= unm_mem[raddr];
  end

endmodule

// ----- rtl/core/cmc_free_scan.sv -----
// ----------------------------------------------------------------------------
// cmc_free_scan
// Taken-output map and the free-output pointer; the pointer steps one
// output per cycle under sequencer control.
// ----------------------------------------------------------------------------
module cmc_free_scan #(
  parameter int PORTS = cmc_pkg::PORTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmc_pkg::scan_ctrl_t         ctrl,
  input  logic [$clog2(PORTS+1)-1:0]  set_size,
  output logic [$clog2(PORTS+1)-1:0]  free_idx,
  output logic                        avail,
  output logic                        hit
);
  import cmc_pkg::*;

  localparam int IW = $clog2(PORTS);
  localparam int CW = $clog2(PORTS + 1);

  logic [PORTS-1:0] taken;
  logic [CW-1:0]    ptr;

  // Pointer still inside the set, and whether it sits on a taken output
  assign avail    = (ptr < set_size);
  assign hit      = avail && taken[ptr[IW-1:0]];
  assign free_idx = ptr;

  // Taken map: set by matched inputs, cleared at end of set
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      taken <= '0;
    end else if (ctrl.mark && (32'(ctrl.mark_port) < 32'(PORTS))) begin
      taken[IW'(ctrl.mark_port)] <= 1'b1;
    end
  end

  // Free-output pointer: the shared incrementer
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      ptr <= '0;
    end else if (ctrl.advance) begin
      ptr <= ptr + CW'(1);
    end
  end

endmodule

// ----- rtl/core/crossbar_matching_completion_core.sv -----
// ----------------------------------------------------------------------------
// crossbar_matching_completion_core
// Completes a partial crossbar matching: free outputs go to unmatched inputs.
// ----------------------------------------------------------------------------
// Usage:
//   items   : one transaction per input port, in port order. is_unmatched
//             marks a port with no output; otherwise target_port is its
//             output. last_entry closes the set. Ports beyond PORTS are
//             dropped, but their last_entry still closes the set.
//   results : one transaction per loaded port, in port order, carrying the
//             granted output, was_filled for ports loaded as unmatched, and
//             last_result on the final one.
// Timing: loading accepts one item per cycle. After the last item, ready is
//   low while results are produced: each result passes the store read, scan
//   check and output load steps, and in the scan check the free-output
//   pointer also steps over each taken output it meets. The single
//   free-output pointer and the one store read port bound how fast results
//   are produced.
// Stall: the output register holds a result until it is taken; the
//   sequencer waits in its output step meanwhile.
// Reset: clears the taken map, load count, pointer and output valid. The
//   port store needs no clearing; only loaded entries are ever read.
// ----------------------------------------------------------------------------
module crossbar_matching_completion_core #(
  parameter int PORTS = cmc_pkg::PORTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cmc_in_if.sink    items,
  cmc_out_if.source results
);
  import cmc_pkg::*;

  localparam int IW = $clog2(PORTS);
  localparam int CW = $clog2(PORTS + 1);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count;      // ports loaded in this set
  logic [CW-1:0]     set_size;   // size of set being emitted
  logic [CW-1:0]     port_idx;   // input port being emitted
  logic              out_valid;
  logic [PORT_W-1:0] out_src;
  logic [PORT_W-1:0] out_grant;
  logic              out_filled;
  logic              out_last;

  logic              in_fire;
  logic              store_we;
  logic              rd_unm;
  logic [PORT_W-1:0] rd_tgt;
  logic [CW-1:0]     free_idx;
  logic              avail;
  logic              hit;
  logic              out_load;
  logic              set_done;
  scan_ctrl_t        ctrl;

  assign items.ready = (state == S_LOAD);
  assign in_fire     = items.valid && items.ready;
  assign store_we    = in_fire && (count < CW'(PORTS));

  // Output register loads once the slot is free
  assign out_load = (state == S_OUT) && (!out_valid || results.ready);
  assign set_done = (port_idx + CW'(1)) == set_size;

  cmc_port_store #(.PORTS(PORTS)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IW-1:0]),
    .wunm  (items.is_unmatched),
    .wtgt  (items.target_port),
    .raddr (port_idx[IW-1:0]),
    .runm  (rd_unm),
    .rtgt  (rd_tgt)
  );

  // Scanner control
  always_comb begin
    ctrl.mark      = store_we && !items.is_unmatched;
    ctrl.mark_port = items.target_port;
    ctrl.advance   = ((state == S_SCAN) && rd_unm && hit) ||
                     (out_load && rd_unm && avail);
    ctrl.clear     = out_load && set_done;
  end

  cmc_free_scan #(.PORTS(PORTS)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .set_size (set_size),
    .free_idx (free_idx),
    .avail    (avail),
    .hit      (hit)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: if (in_fire && items.last_entry) state_next = S_READ;
      S_READ: state_next = S_SCAN;
      S_SCAN: if (!(rd_unm && hit)) state_next = S_OUT;
      S_OUT: begin
        if (out_load) state_next = set_done ? S_LOAD : S_READ;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      set_size <= '0;
      port_idx <= '0;
    end else begin
      state <= state_next;
      if (store_we) count <= count + CW'(1);
      if (in_fire && items.last_entry) begin
        set_size <= store_we ? count + CW'(1) : count;
        port_idx <= '0;
      end
      if (out_load) begin
        if (set_done) count <= '0;
        port_idx <= port_idx + CW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_src    <= PORT_W'(port_idx);
      out_filled <= rd_unm;
      out_last   <= set_done;
      if (!rd_unm)     out_grant <= rd_tgt;
      else if (avail)  out_grant <= PORT_W'(free_idx);
      else             out_grant <= '0;
    end
  end

  assign results.valid        = out_valid;
  assign results.source_port  = out_src;
  assign results.granted_port = out_grant;
  assign results.was_filled   = out_filled;
  assign results.last_result  = out_last;

  // Load count never passes the port count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PORTS))
    else $error("load count above PORTS");

  // A filled grant never lands on a taken output
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    (out_load && rd_unm && avail) |-> !hit)
    else $error("filled grant on taken output");

  // Closing result clears the set
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && set_done) |=> (count == '0) && (state == S_LOAD))
    else $error("set not cleared after last result");

  // Emitted port index stays inside the set
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (port_idx < set_size))
    else $error("emitted port outside set");

endmodule
